// ----- hw/rtl/ecam_pkg.sv -----
// Shared types, constants and tables for the camera orientation block.
// No dependencies; every other file of the block imports this package.
package ecam_pkg;

  localparam int ANGLE_FRAC_BITS  = 7;
  localparam int VECTOR_FRAC_BITS = 14;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ANG_W   = 16;            // stored angle width
  localparam int IN_W    = 17;            // input angle width
  localparam int SUM_W   = 18;            // angle sum width
  localparam int VEC_W   = 16;            // output vector component width
  localparam int CQ_W    = 32;            // CORDIC x, y, z width
  localparam int ATAN_IDX_W = 5;
  localparam int Z_SHIFT = 24 - ANGLE_FRAC_BITS;

  localparam int HALF_TURN_I    = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER_TURN_I = 90 << ANGLE_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF_TURN    = SUM_W'(HALF_TURN_I);
  localparam logic signed [SUM_W-1:0] FULL_TURN    = SUM_W'(2 * HALF_TURN_I);
  localparam logic signed [SUM_W-1:0] QUARTER_TURN = SUM_W'(QUARTER_TURN_I);

  localparam logic signed [CQ_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic                    LIMIT_EN_RST  = 1'b1;
  localparam logic signed [ANG_W-1:0] MIN_PITCH_RST = -16'sd11392;
  localparam logic signed [ANG_W-1:0] MAX_PITCH_RST = 16'sd11392;

  typedef enum logic [1:0] {
    OP_ROTATE = 2'd0,
    OP_SET    = 2'd1,
    OP_LIMIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_LIMIT_EN  = 2'd0,
    CFG_MIN_PITCH = 2'd1,
    CFG_MAX_PITCH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VS_FWD_X = 2'd0,
    VS_FWD_Z = 2'd1,
    VS_UP_X  = 2'd2,
    VS_UP_Z  = 2'd3
  } vec_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ITER,
    ST_FIX,
    ST_MUL,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic                    limit_en;
    logic signed [ANG_W-1:0] min_pitch;
    logic signed [ANG_W-1:0] max_pitch;
  } cfg_t;

  typedef struct packed {
    logic                  capture;
    logic                  init;
    logic                  iter;
    logic [ATAN_IDX_W-1:0] iter_idx;
    logic                  fix;
    logic                  mul_en;
    vec_sel_e              mul_sel;
    logic                  rnd_en;
    vec_sel_e              rnd_sel;
    logic                  load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } stat_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch_now;
    logic signed [ANG_W-1:0] yaw_now;
    logic signed [VEC_W-1:0] fwd_x;
    logic signed [VEC_W-1:0] fwd_y;
    logic signed [VEC_W-1:0] fwd_z;
    logic signed [VEC_W-1:0] right_x;
    logic signed [VEC_W-1:0] right_z;
    logic signed [VEC_W-1:0] up_x;
    logic signed [VEC_W-1:0] up_y;
    logic signed [VEC_W-1:0] up_z;
  } res_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [CQ_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] i);
    logic signed [CQ_W-1:0] r;
    case (i)
      5'd0:  r = 32'sd754974720;
      5'd1:  r = 32'sd445687602;
      5'd2:  r = 32'sd235489089;
      5'd3:  r = 32'sd119537938;
      5'd4:  r = 32'sd60000934;
      5'd5:  r = 32'sd30029717;
      5'd6:  r = 32'sd15018523;
      5'd7:  r = 32'sd7509720;
      5'd8:  r = 32'sd3754917;
      5'd9:  r = 32'sd1877466;
      5'd10: r = 32'sd938734;
      5'd11: r = 32'sd469367;
      5'd12: r = 32'sd234684;
      5'd13: r = 32'sd117342;
      5'd14: r = 32'sd58671;
      5'd15: r = 32'sd29335;
      5'd16: r = 32'sd14668;
      5'd17: r = 32'sd7334;
      5'd18: r = 32'sd3667;
      5'd19: r = 32'sd1833;
      5'd20: r = 32'sd917;
      5'd21: r = 32'sd458;
      5'd22: r = 32'sd229;
      5'd23: r = 32'sd115;
      5'd24: r = 32'sd57;
      5'd25: r = 32'sd29;
      5'd26: r = 32'sd14;
      5'd27: r = 32'sd7;
      5'd28: r = 32'sd4;
      5'd29: r = 32'sd2;
      5'd30: r = 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/ecam_if.sv -----
// Channel interfaces of the camera orientation block: input, result, config.
// Depends on ecam_pkg.
interface ecam_in_if;
  import ecam_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             op;
  logic signed [IN_W-1:0] pitch_value;
  logic signed [IN_W-1:0] yaw_value;
  modport source (output valid, op, pitch_value, yaw_value, input ready);
  modport sink (input valid, op, pitch_value, yaw_value, output ready);
endinterface

interface ecam_out_if;
  import ecam_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] pitch_now;
  logic signed [ANG_W-1:0] yaw_now;
  logic signed [VEC_W-1:0] fwd_x;
  logic signed [VEC_W-1:0] fwd_y;
  logic signed [VEC_W-1:0] fwd_z;
  logic signed [VEC_W-1:0] right_x;
  logic signed [VEC_W-1:0] right_z;
  logic signed [VEC_W-1:0] up_x;
  logic signed [VEC_W-1:0] up_y;
  logic signed [VEC_W-1:0] up_z;
  modport source (output valid, pitch_now, yaw_now, fwd_x, fwd_y, fwd_z, right_x, right_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, pitch_now, yaw_now, fwd_x, fwd_y, fwd_z, right_x, right_z,
                up_x, up_y, up_z, output ready);
endinterface

interface ecam_cfg_if;
  import ecam_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [ANG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/euler_camera_orientation.sv -----
// Top level of the camera orientation block: config registers, sequencer,
// datapath. Depends on ecam_pkg, ecam_if, ecam_ctrl and ecam_datapath.
//
// Keeps a camera pitch and yaw in 1/128 degree steps and returns, for every
// input beat, one result beat with both angles and the forward, right and up
// unit vectors in Q1.14. Op 0 adds the deltas, op 1 sets absolute angles,
// op 2 re-applies the pitch limits; op 3 reports the current state unchanged.
// Pitch is clamped to [min_pitch, max_pitch] when limit_enable is set and is
// always saturated to +/-180 degrees; yaw wraps into [-180, 180]. An item
// passes through these steps in order: update the angles, load the CORDIC,
// run CORDIC_STEPS micro-rotations on the pitch and yaw lanes side by side,
// fix signs, use the single shared 32x32 multiplier, and load the result
// register. The input is ready again as soon as the result is loaded, so the
// next item runs while the previous result still waits on the output channel.
// Config writes are taken every cycle and must only come while the block is
// idle.
module euler_camera_orientation #(
  parameter int CORDIC_STEPS = ecam_pkg::CORDIC_STEPS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  ecam_in_if.sink    in_ch,
  ecam_out_if.source out_ch,
  ecam_cfg_if.sink   cfg_ch
);
  import ecam_pkg::*;

  // config registers, always ready
  cfg_t cfg_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_en  <= LIMIT_EN_RST;
      cfg_q.min_pitch <= MIN_PITCH_RST;
      cfg_q.max_pitch <= MAX_PITCH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LIMIT_EN:  cfg_q.limit_en  <= cfg_ch.data[0];
        CFG_MIN_PITCH: cfg_q.min_pitch <= cfg_ch.data;
        CFG_MAX_PITCH: cfg_q.max_pitch <= cfg_ch.data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // sequencer and datapath
  stat_t stat;
  cmd_t  cmd;
  res_t  res;
  logic  out_valid;

  assign stat.in_valid  = in_ch.valid;
  assign stat.out_ready = out_ch.ready;

  ecam_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_valid)
  );

  ecam_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .op_i          (in_ch.op),
    .pitch_value_i (in_ch.pitch_value),
    .yaw_value_i   (in_ch.yaw_value),
    .res_o         (res)
  );

  // result channel
  assign out_ch.valid     = out_valid;
  assign out_ch.pitch_now = res.pitch_now;
  assign out_ch.yaw_now   = res.yaw_now;
  assign out_ch.fwd_x     = res.fwd_x;
  assign out_ch.fwd_y     = res.fwd_y;
  assign out_ch.fwd_z     = res.fwd_z;
  assign out_ch.right_x   = res.right_x;
  assign out_ch.right_z   = res.right_z;
  assign out_ch.up_x      = res.up_x;
  assign out_ch.up_y      = res.up_y;
  assign out_ch.up_z      = res.up_z;

  // an accepted beat keeps the input closed until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while previous item in flight");

  // a loaded result never coincides with an open input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !in_ch.ready)
    else $error("result loaded while input ready");

  // reported angles stay within half a turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.pitch_now <= 16'sd23040 && out_ch.pitch_now >= -16'sd23040 &&
                      out_ch.yaw_now <= 16'sd23040 && out_ch.yaw_now >= -16'sd23040))
    else $error("angle out of range");

  // forward y component stays a unit value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.fwd_y <= 16'sd16384 && out_ch.fwd_y >= -16'sd16384))
    else $error("vector component out of range");

endmodule

// ----- hw/rtl/ecam_ctrl.sv -----
// Sequencer of the camera orientation block: update, CORDIC, multiply, load.
// Depends on ecam_pkg; drives ecam_datapath through cmd_t.
module ecam_ctrl #(
  parameter int CORDIC_STEPS = ecam_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ecam_pkg::stat_t stat_i,
  output ecam_pkg::cmd_t  cmd_o,
  output logic           in_ready_o,
  output logic           out_valid_o
);
  import ecam_pkg::*;

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [2:0] MUL_LAST = 3'd4;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [2:0]       mul_q, mul_d;
  logic             out_valid_q, out_valid_d;
  logic             load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (stat_i.in_valid) state_d = ST_INIT;
      ST_INIT: state_d = ST_ITER;
      ST_ITER: if (step_q == LAST_STEP) state_d = ST_FIX;
      ST_FIX:  state_d = ST_MUL;
      ST_MUL:  if (mul_q == MUL_LAST) state_d = ST_LOAD;
      ST_LOAD: if (!out_valid_q || stat_i.out_ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = vec_sel_e'(mul_q[1:0]);
    cmd_o.rnd_sel  = vec_sel_e'(mul_q[1:0] - 2'd1);
    cmd_o.iter_idx = ATAN_IDX_W'(step_q);
    load           = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_o.capture = stat_i.in_valid;
      ST_INIT: cmd_o.init = 1'b1;
      ST_ITER: cmd_o.iter = 1'b1;
      ST_FIX:  cmd_o.fix = 1'b1;
      ST_MUL: begin
        cmd_o.mul_en = (mul_q != MUL_LAST);
        cmd_o.rnd_en = (mul_q != 3'd0);
      end
      ST_LOAD: load = !out_valid_q || stat_i.out_ready;
      default: ;
    endcase
    cmd_o.load = load;
  end

  always_comb begin
    step_d      = (state_q == ST_ITER) ? step_q + 1'b1 : '0;
    mul_d       = (state_q == ST_MUL) ? mul_q + 3'd1 : '0;
    out_valid_d = load | (out_valid_q & !stat_i.out_ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mul_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      mul_q       <= mul_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/ecam_datapath.sv -----
// Angle state, limit and wrap logic, two CORDIC lanes, shared multiplier
// and result register. Depends on ecam_pkg; commanded by ecam_ctrl.
module ecam_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ecam_pkg::cmd_t                   cmd_i,
  input  ecam_pkg::cfg_t                   cfg_i,
  input  logic [1:0]                       op_i,
  input  logic signed [ecam_pkg::IN_W-1:0] pitch_value_i,
  input  logic signed [ecam_pkg::IN_W-1:0] yaw_value_i,
  output ecam_pkg::res_t                   res_o
);
  import ecam_pkg::*;

  localparam int SH30 = 30 - VECTOR_FRAC_BITS;
  localparam int SH60 = 60 - VECTOR_FRAC_BITS;
  localparam logic signed [64:0] VEC_ONE = 65'sd1 <<< VECTOR_FRAC_BITS;

  function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [64:0] t);
    logic signed [64:0] c;
    c = t;
    if (c > VEC_ONE) c = VEC_ONE;
    if (c < -VEC_ONE) c = -VEC_ONE;
    return VEC_W'(c);
  endfunction

  function automatic logic signed [VEC_W-1:0] rnd30(input logic signed [CQ_W:0] v);
    logic signed [64:0] t;
    t = (65'(v) + (65'sd1 <<< (SH30 - 1))) >>> SH30;
    return sat_vec(t);
  endfunction

  function automatic logic signed [VEC_W-1:0] rnd60(input logic signed [63:0] v);
    logic signed [64:0] t;
    t = (65'(v) + (65'sd1 <<< (SH60 - 1))) >>> SH60;
    return sat_vec(t);
  endfunction

  logic signed [ANG_W-1:0] pitch_q, yaw_q;

  // angle update
  logic signed [SUM_W-1:0] p_sum, y_sum, p_lim, y_wrap;
  logic                    do_limit;

  always_comb begin
    do_limit = 1'b1;
    case (op_i)
      OP_ROTATE: begin
        p_sum = SUM_W'(pitch_q) + SUM_W'(pitch_value_i);
        y_sum = SUM_W'(yaw_q) + SUM_W'(yaw_value_i);
      end
      OP_SET: begin
        p_sum = SUM_W'(pitch_value_i);
        y_sum = SUM_W'(yaw_value_i);
      end
      OP_LIMIT: begin
        p_sum = SUM_W'(pitch_q);
        y_sum = SUM_W'(yaw_q);
      end
      default: begin
        p_sum    = SUM_W'(pitch_q);
        y_sum    = SUM_W'(yaw_q);
        do_limit = 1'b0;
      end
    endcase

    p_lim = p_sum;
    if (do_limit) begin
      if (cfg_i.limit_en) begin
        if (p_sum < SUM_W'(cfg_i.min_pitch)) p_lim = SUM_W'(cfg_i.min_pitch);
        else if (p_sum > SUM_W'(cfg_i.max_pitch)) p_lim = SUM_W'(cfg_i.max_pitch);
      end
      if (p_lim > HALF_TURN) p_lim = HALF_TURN;
      if (p_lim < -HALF_TURN) p_lim = -HALF_TURN;
    end

    y_wrap = y_sum;
    if (y_wrap > HALF_TURN) y_wrap = y_wrap - FULL_TURN;
    else if (y_wrap < -HALF_TURN) y_wrap = y_wrap + FULL_TURN;
    // a full-width delta can leave the sum more than one turn away
    if (y_wrap > HALF_TURN) y_wrap = y_wrap - FULL_TURN;
    else if (y_wrap < -HALF_TURN) y_wrap = y_wrap + FULL_TURN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      yaw_q   <= '0;
    end else if (cmd_i.capture) begin
      pitch_q <= ANG_W'(p_lim);
      yaw_q   <= ANG_W'(y_wrap);
    end
  end

  // fold into [-90, 90] degrees; lane 0 pitch, lane 1 yaw
  logic signed [CQ_W-1:0] z0   [2];
  logic                   neg0 [2];
  logic signed [SUM_W-1:0] ang [2];
  logic signed [SUM_W-1:0] fold [2];

  always_comb begin
    ang[0] = SUM_W'(pitch_q);
    ang[1] = SUM_W'(yaw_q);
    for (int l = 0; l < 2; l++) begin
      fold[l] = ang[l];
      neg0[l] = 1'b0;
      if (ang[l] > QUARTER_TURN) begin
        fold[l] = ang[l] - HALF_TURN;
        neg0[l] = 1'b1;
      end else if (ang[l] < -QUARTER_TURN) begin
        fold[l] = ang[l] + HALF_TURN;
        neg0[l] = 1'b1;
      end
      z0[l] = CQ_W'(fold[l]) <<< Z_SHIFT;
    end
  end

  // CORDIC lanes, one micro-rotation per cycle
  logic signed [CQ_W-1:0] x_q [2];
  logic signed [CQ_W-1:0] y_q [2];
  logic signed [CQ_W-1:0] z_q [2];
  logic                   neg_q [2];
  logic signed [CQ_W-1:0] atan_i;

  assign atan_i = atan_deg(cmd_i.iter_idx);

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.init) begin
        x_q[l]   <= CORDIC_GAIN;
        y_q[l]   <= '0;
        z_q[l]   <= z0[l];
        neg_q[l] <= neg0[l];
      end else if (cmd_i.iter) begin
        if (z_q[l] >= 0) begin
          x_q[l] <= x_q[l] - (y_q[l] >>> cmd_i.iter_idx);
          y_q[l] <= y_q[l] + (x_q[l] >>> cmd_i.iter_idx);
          z_q[l] <= z_q[l] - atan_i;
        end else begin
          x_q[l] <= x_q[l] + (y_q[l] >>> cmd_i.iter_idx);
          y_q[l] <= y_q[l] - (x_q[l] >>> cmd_i.iter_idx);
          z_q[l] <= z_q[l] + atan_i;
        end
      end
    end
  end

  // signed sine and cosine, sign of cos(pitch)
  logic                   sg_pos;
  logic signed [CQ_W-1:0] sp_q, cp_q, sy_q, cy_q, nsp_q;
  logic signed [CQ_W-1:0] sp_n;

  assign sg_pos = (SUM_W'(pitch_q) <= QUARTER_TURN) && (SUM_W'(pitch_q) >= -QUARTER_TURN);
  assign sp_n   = neg_q[0] ? -y_q[0] : y_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      sp_q  <= sp_n;
      cp_q  <= neg_q[0] ? -x_q[0] : x_q[0];
      sy_q  <= neg_q[1] ? -y_q[1] : y_q[1];
      cy_q  <= neg_q[1] ? -x_q[1] : x_q[1];
      nsp_q <= sg_pos ? -sp_n : sp_n;
    end
  end

  // shared multiplier; each product is registered and then rounded
  logic signed [CQ_W-1:0] mul_a, mul_b;
  logic signed [63:0]     prod_q;
  logic signed [VEC_W-1:0] fwd_x_q, fwd_z_q, up_x_q, up_z_q, rnd_v;

  always_comb begin
    unique case (cmd_i.mul_sel)
      VS_FWD_X: begin mul_a = sy_q;  mul_b = cp_q; end
      VS_FWD_Z: begin mul_a = cy_q;  mul_b = cp_q; end
      VS_UP_X:  begin mul_a = nsp_q; mul_b = sy_q; end
      VS_UP_Z:  begin mul_a = nsp_q; mul_b = cy_q; end
      default:  begin mul_a = sy_q;  mul_b = cp_q; end
    endcase
  end

  assign rnd_v = rnd60(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
    if (cmd_i.rnd_en) begin
      unique case (cmd_i.rnd_sel)
        VS_FWD_X: fwd_x_q <= rnd_v;
        VS_FWD_Z: fwd_z_q <= rnd_v;
        VS_UP_X:  up_x_q  <= rnd_v;
        VS_UP_Z:  up_z_q  <= rnd_v;
        default:  ;
      endcase
    end
  end

  // result register
  logic signed [CQ_W:0] cy_w, sy_w, cp_w;
  res_t res_q;

  assign cy_w = (CQ_W+1)'(cy_q);
  assign sy_w = (CQ_W+1)'(sy_q);
  assign cp_w = (CQ_W+1)'(cp_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q.pitch_now <= pitch_q;
      res_q.yaw_now   <= yaw_q;
      res_q.fwd_x     <= fwd_x_q;
      res_q.fwd_y     <= rnd30((CQ_W+1)'(sp_q));
      res_q.fwd_z     <= fwd_z_q;
      res_q.right_x   <= rnd30(sg_pos ? cy_w : -cy_w);
      res_q.right_z   <= rnd30(sg_pos ? -sy_w : sy_w);
      res_q.up_x      <= up_x_q;
      res_q.up_y      <= rnd30(sg_pos ? cp_w : -cp_w);
      res_q.up_z      <= up_z_q;
    end
  end

  assign res_o = res_q;

endmodule
